// ===== rtl/ldrs_pkg.sv =====
package ldrs_pkg;

  // Number of digit positions sent in the digit frame (1 to 6)
  localparam int DIGITS = 4;
  // Segment slots reachable through the 2-bit digit index
  localparam int SEG_SLOTS = 4;
  localparam int SEG_IDX_W = 2;
  localparam int BYTE_W = 8;
  localparam int BYTE_NUM_W = 3;
  localparam int BRIGHT_W = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_TICK,
    FUNC_LOAD,
    FUNC_FULL,
    FUNC_BRIGHT
  } func_t;

  typedef enum logic [1:0] {
    CFG_DATA_CMD,
    CFG_ADDR_CMD,
    CFG_DISP_CMD,
    CFG_BRIGHTNESS
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_BYTE,
    PH_STOP
  } phase_t;

  localparam logic [1:0] FRAME_DATA = 2'd0;
  localparam logic [1:0] FRAME_DIGITS = 2'd1;
  localparam logic [1:0] FRAME_DISPLAY = 2'd2;

  // Sub-steps inside one bit, start or stop
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_cmd;
    logic [BYTE_W-1:0] addr_cmd;
    logic [BYTE_W-1:0] disp_cmd;
    logic [BRIGHT_W-1:0] brightness;
  } cfg_regs_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy;
  } pin_status_t;

endpackage

// ===== rtl/ldrs_seg_store.sv =====
module ldrs_seg_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ldrs_pkg::SEG_IDX_W-1:0]   wr_idx,
  input  logic [ldrs_pkg::BYTE_W-1:0]      wr_data,
  input  logic [ldrs_pkg::BYTE_NUM_W-1:0]  rd_byte_num,
  output logic [ldrs_pkg::BYTE_W-1:0]      rd_seg
);
  import ldrs_pkg::*;

  logic [BYTE_W-1:0]     seg_r [SEG_SLOTS];
  logic [BYTE_W-1:0]     seg_nxt [SEG_SLOTS];
  logic [BYTE_NUM_W-1:0] digit;

  // Loads past the configured digit count are dropped
  always_comb begin
    for (int i = 0; i < SEG_SLOTS; i++) begin
      seg_nxt[i] = seg_r[i];
    end
    if (wr_en && (int'(wr_idx) < DIGITS)) begin
      seg_nxt[wr_idx] = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SEG_SLOTS; i++) begin
      if (!rst_n) begin
        seg_r[i] <= '0;
      end else begin
        seg_r[i] <= seg_nxt[i];
      end
    end
  end

  // Byte 0 of the digit frame is the address command; digit d is byte d+1.
  // Digits that cannot be loaded go out as zero.
  assign digit = rd_byte_num - BYTE_NUM_W'(1);

  always_comb begin
    if ((rd_byte_num != '0) && (int'(digit) < DIGITS) && (int'(digit) < SEG_SLOTS)) begin
      rd_seg = seg_r[digit[SEG_IDX_W-1:0]];
    end else begin
      rd_seg = '0;
    end
  end

endmodule

// ===== rtl/ldrs_seq.sv =====
module ldrs_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  ldrs_pkg::func_t                  func,
  input  ldrs_pkg::cfg_regs_t              cfg,
  input  logic [ldrs_pkg::BYTE_W-1:0]      seg_byte,
  output logic [ldrs_pkg::BYTE_NUM_W-1:0]  byte_num,
  output ldrs_pkg::pin_status_t            status_nxt
);
  import ldrs_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [1:0]            frame_r, frame_nxt;
  logic [BYTE_NUM_W-1:0] byte_r, byte_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [1:0]            sub_r, sub_nxt;
  logic                  ack_r, ack_nxt;
  logic                  bonly_r, bonly_nxt;
  logic                  clk_pin_r, clk_pin_nxt;
  logic                  dio_pin_r, dio_pin_nxt;

  logic [BYTE_W-1:0]     cur_byte;
  logic [BYTE_NUM_W-1:0] frame_bytes;
  logic [BYTE_NUM_W-1:0] byte_inc;
  logic                  busy;

  assign busy = (phase_r != PH_IDLE);
  assign byte_num = byte_r;
  assign byte_inc = byte_r + BYTE_NUM_W'(1);
  assign frame_bytes = (frame_r == FRAME_DIGITS) ? BYTE_NUM_W'(DIGITS + 1)
                                                 : BYTE_NUM_W'(1);

  always_comb begin
    priority if (frame_r == FRAME_DATA) begin
      cur_byte = cfg.data_cmd;
    end else if (frame_r == FRAME_DIGITS) begin
      cur_byte = (byte_r == '0) ? cfg.addr_cmd : seg_byte;
    end else begin
      cur_byte = cfg.disp_cmd | {{(BYTE_W-BRIGHT_W){1'b0}}, cfg.brightness};
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    frame_nxt   = frame_r;
    byte_nxt    = byte_r;
    bit_nxt     = bit_r;
    sub_nxt     = sub_r;
    ack_nxt     = ack_r;
    bonly_nxt   = bonly_r;
    clk_pin_nxt = clk_pin_r;
    dio_pin_nxt = dio_pin_r;

    if (step_en) begin
      unique case (func)
        FUNC_TICK: begin
          unique case (phase_r)
            PH_IDLE: begin
            end
            PH_START: begin
              if (sub_r == SUB_0) begin
                dio_pin_nxt = 1'b0;
                sub_nxt = SUB_1;
              end else begin
                clk_pin_nxt = 1'b0;
                phase_nxt = PH_BYTE;
                byte_nxt = '0;
                bit_nxt = '0;
                ack_nxt = 1'b0;
                sub_nxt = SUB_0;
              end
            end
            PH_BYTE: begin
              priority if (sub_r == SUB_0) begin
                if (ack_r) begin
                  clk_pin_nxt = 1'b0;
                end else begin
                  dio_pin_nxt = cur_byte[bit_r];
                end
                sub_nxt = SUB_1;
              end else if (sub_r == SUB_1) begin
                clk_pin_nxt = 1'b1;
                sub_nxt = SUB_2;
              end else begin
                clk_pin_nxt = 1'b0;
                sub_nxt = SUB_0;
                if (ack_r) begin
                  // acknowledge clock done: next byte or close the frame
                  ack_nxt = 1'b0;
                  bit_nxt = '0;
                  byte_nxt = byte_inc;
                  if (byte_inc >= frame_bytes) begin
                    phase_nxt = PH_STOP;
                  end
                end else if (bit_r == 3'd7) begin
                  ack_nxt = 1'b1;
                end else begin
                  bit_nxt = bit_r + 3'd1;
                end
              end
            end
            PH_STOP: begin
              priority if (sub_r == SUB_0) begin
                dio_pin_nxt = 1'b0;
                sub_nxt = SUB_1;
              end else if (sub_r == SUB_1) begin
                clk_pin_nxt = 1'b1;
                sub_nxt = SUB_2;
              end else begin
                dio_pin_nxt = 1'b1;
                sub_nxt = SUB_0;
                byte_nxt = '0;
                priority if (frame_r == FRAME_DATA) begin
                  frame_nxt = bonly_r ? FRAME_DISPLAY : FRAME_DIGITS;
                  phase_nxt = PH_START;
                end else if (frame_r == FRAME_DIGITS) begin
                  frame_nxt = FRAME_DISPLAY;
                  phase_nxt = PH_START;
                end else begin
                  frame_nxt = FRAME_DATA;
                  phase_nxt = PH_IDLE;
                end
              end
            end
          endcase
        end
        FUNC_LOAD: begin
        end
        FUNC_FULL, FUNC_BRIGHT: begin
          // arm only; requests during a sequence are dropped
          if (!busy) begin
            bonly_nxt = (func == FUNC_BRIGHT);
            frame_nxt = FRAME_DATA;
            byte_nxt  = '0;
            bit_nxt   = '0;
            sub_nxt   = SUB_0;
            ack_nxt   = 1'b0;
            phase_nxt = PH_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      frame_r   <= FRAME_DATA;
      byte_r    <= '0;
      bit_r     <= '0;
      sub_r     <= SUB_0;
      ack_r     <= 1'b0;
      bonly_r   <= 1'b0;
      clk_pin_r <= 1'b0;
      dio_pin_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      frame_r   <= frame_nxt;
      byte_r    <= byte_nxt;
      bit_r     <= bit_nxt;
      sub_r     <= sub_nxt;
      ack_r     <= ack_nxt;
      bonly_r   <= bonly_nxt;
      clk_pin_r <= clk_pin_nxt;
      dio_pin_r <= dio_pin_nxt;
    end
  end

  assign status_nxt.clk_level = clk_pin_nxt;
  assign status_nxt.dio_level = dio_pin_nxt;
  assign status_nxt.busy      = (phase_nxt != PH_IDLE);

endmodule

// ===== rtl/led_display_refresh_serializer.sv =====
// Refresh serializer for a two-wire seven-segment LED driver.
// Input channel (in_valid/in_ready): one beat per command. in_func selects
// tick, segment load, full refresh or brightness-only refresh; load beats
// carry in_digit_index and in_segments. Every tick beat makes at most one
// change on the clock or data pin of the driver.
// Result channel (out_valid/out_ready): exactly one beat per input beat,
// in order, with the pin levels after that command and a busy flag that is
// high while a refresh sequence is still being sent.
// Configuration port (cfg_we/cfg_index/cfg_wdata): single-cycle writes to
// the data, address and display command bytes and the brightness level.
// Each beat goes from the input register, through the sequencer state
// update, into the result register. Throughput: one beat per cycle
// while out_ready is high.
// Reset (rst_n low, synchronous): pins low, sequencer idle, segment store
// cleared, config back to its defaults, both channels empty.
// Stall: when out_ready is low the result holds; the input register still
// takes one more beat, then in_ready drops until the result moves on.
module led_display_refresh_serializer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [ldrs_pkg::SEG_IDX_W-1:0]  in_digit_index,
  input  logic [ldrs_pkg::BYTE_W-1:0]     in_segments,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_clk_level,
  output logic                            out_dio_level,
  output logic                            out_busy_res,
  input  logic                            cfg_we,
  input  logic [ldrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldrs_pkg::BYTE_W-1:0]     cfg_wdata
);
  import ldrs_pkg::*;

  // Configuration registers
  cfg_regs_t cfg_r, cfg_nxt;

  // Input register
  logic                 item_v_r, item_v_nxt;
  logic [1:0]           item_func_r, item_func_nxt;
  logic [SEG_IDX_W-1:0] item_idx_r, item_idx_nxt;
  logic [BYTE_W-1:0]    item_seg_r, item_seg_nxt;

  // Result register
  logic        out_v_r, out_v_nxt;
  pin_status_t out_st_r, out_st_nxt;

  logic                  in_fire;
  logic                  move;
  func_t                 item_func;
  logic [BYTE_NUM_W-1:0] byte_num;
  logic [BYTE_W-1:0]     seg_byte;
  pin_status_t           status_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DATA_CMD:   cfg_nxt.data_cmd   = cfg_wdata;
        CFG_ADDR_CMD:   cfg_nxt.addr_cmd   = cfg_wdata;
        CFG_DISP_CMD:   cfg_nxt.disp_cmd   = cfg_wdata;
        CFG_BRIGHTNESS: cfg_nxt.brightness = cfg_wdata[BRIGHT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_cmd   <= 8'd64;
      cfg_r.addr_cmd   <= 8'd192;
      cfg_r.disp_cmd   <= 8'd136;
      cfg_r.brightness <= 3'd7;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Advance the held item into the sequencer when the result slot frees up
  assign move      = item_v_r && (!out_v_r || out_ready);
  assign in_ready  = !item_v_r || move;
  assign in_fire   = in_valid && in_ready;
  assign item_func = func_t'(item_func_r);

  always_comb begin
    item_v_nxt    = in_fire || (item_v_r && !move);
    item_func_nxt = in_fire ? in_func : item_func_r;
    item_idx_nxt  = in_fire ? in_digit_index : item_idx_r;
    item_seg_nxt  = in_fire ? in_segments : item_seg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_func_r <= item_func_nxt;
    item_idx_r  <= item_idx_nxt;
    item_seg_r  <= item_seg_nxt;
  end

  ldrs_seg_store u_seg_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (move && (item_func == FUNC_LOAD)),
    .wr_idx      (item_idx_r),
    .wr_data     (item_seg_r),
    .rd_byte_num (byte_num),
    .rd_seg      (seg_byte)
  );

  ldrs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (move),
    .func       (item_func),
    .cfg        (cfg_r),
    .seg_byte   (seg_byte),
    .byte_num   (byte_num),
    .status_nxt (status_nxt)
  );

  // Capture the pin levels after the item; hold while the receiver stalls
  always_comb begin
    out_v_nxt  = move || (out_v_r && !out_ready);
    out_st_nxt = move ? status_nxt : out_st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_st_r <= out_st_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_clk_level = out_st_r.clk_level;
  assign out_dio_level = out_st_r.dio_level;
  assign out_busy_res  = out_st_r.busy;

endmodule

// ===== rtl/ldrs_checker.sv =====
module ldrs_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_clk_level,
  input logic out_dio_level,
  input logic out_busy_res
);

  logic out_fire;

  assign out_fire = out_valid && out_ready;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_clk_level)
      && $stable(out_dio_level) && $stable(out_busy_res))
    else $error("result beat changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Consecutive items never move both pins
  a_one_pin_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire ##1 out_fire |-> $stable(out_clk_level) || $stable(out_dio_level))
    else $error("both pins changed on one item");

  // Pins hold while the sequencer is idle
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_busy_res) ##1 (out_fire && !out_busy_res)
      |-> $stable(out_clk_level) && $stable(out_dio_level))
    else $error("pin moved while idle");

endmodule

bind led_display_refresh_serializer ldrs_checker u_ldrs_checker (.*);
